// ----- rtl/core/tma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types and constants for the temperature moving average core.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int READING_W = 14;

  typedef logic signed [READING_W-1:0] reading_t;

endpackage

// ----- rtl/core/tma_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_if
// Request and result channels of the temperature moving average core.
// ----------------------------------------------------------------------------
interface tma_in_if;
  import tma_pkg::*;

  logic     valid;
  logic     ready;
  reading_t reading;
  logic     fault;

  modport source (output valid, output reading, output fault, input ready);
  modport sink   (input valid, input reading, input fault, output ready);
endinterface

interface tma_out_if;
  import tma_pkg::*;

  logic     valid;
  logic     ready;
  reading_t average;
  logic     warming_up;

  modport source (output valid, output average, output warming_up, input ready);
  modport sink   (input valid, input average, input warming_up, output ready);
endinterface

// ----- rtl/core/tma_history_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_history_ram
// Reading history store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tma_history_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output tma_pkg::reading_t rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  tma_pkg::reading_t wr_data
);
  import tma_pkg::*;

  reading_t mem [DEPTH];
  reading_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tma_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tma_divider #(
  parameter int SUM_W = 17,
  parameter int CNT_W = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic        [CNT_W-1:0] divisor,
  output logic                    done,
  output tma_pkg::reading_t       quotient
);
  import tma_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [SUM_W-1:0]  quo_r;
  logic              neg_r;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;
  logic [SUM_W-1:0]  signed_quo;

  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(SUM_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= mag;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign signed_quo = neg_r ? -quo_r : quo_r;
  assign quotient   = signed_quo[READING_W-1:0];
  assign done       = done_r;

endmodule

// ----- rtl/core/temperature_moving_average_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_moving_average_core
// Moving average of thermocouple readings over a ring buffer of WINDOW
// entries, faulted readings replaced by the last good one.
//
//   channel  direction  fields                  handshake
//   in_ch    sink       reading, fault          valid / ready
//   out_ch   source     average, warming_up     valid / ready
//
// A request is handled in steps: the history RAM is read, then it and the
// running total are updated while the bit-serial divider is started, the
// divider runs, and finally the output register is loaded.
// Reset is synchronous; no clearing pass, slots not yet written read as zero
// through the fill count. A held result stalls the output register load and
// blocks new requests; once loaded, the next request is taken while it waits.
// ----------------------------------------------------------------------------
module temperature_moving_average_core #(
  parameter int WINDOW = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  tma_in_if.sink    in_ch,
  tma_out_if.source out_ch
);
  import tma_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = READING_W + $clog2(WINDOW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV
  } state_t;

  state_t                   state_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [CNT_W-1:0]         filled_r;
  logic signed [SUM_W-1:0]  total_r;
  reading_t                 last_good_r;
  reading_t                 chosen_r;
  logic                     warming_r;
  logic                     out_valid_r;
  reading_t                 average_r;
  logic                     out_warming_r;

  logic                     in_fire;
  reading_t                 chosen_nxt;
  reading_t                 rd_data;
  reading_t                 old_entry;
  logic signed [SUM_W-1:0]  total_nxt;
  logic [CNT_W-1:0]         filled_nxt;
  logic [SLOT_W-1:0]        slot_nxt;
  logic                     div_done;
  reading_t                 quotient;
  logic                     out_free;
  logic                     out_load;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign chosen_nxt = in_ch.fault ? last_good_r : in_ch.reading;
  assign old_entry  = (filled_r == CNT_W'(WINDOW)) ? rd_data : '0;
  assign total_nxt  = total_r - SUM_W'(old_entry) + SUM_W'(chosen_r);
  assign filled_nxt = (filled_r == CNT_W'(WINDOW)) ? filled_r : filled_r + 1'b1;
  assign slot_nxt   = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign out_load   = (state_r == S_DIV) && div_done && out_free;

  tma_history_ram #(
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (slot_r),
    .rd_data (rd_data),
    .wr_en   (state_r == S_UPDATE),
    .wr_addr (slot_r),
    .wr_data (chosen_r)
  );

  tma_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_UPDATE),
    .dividend (total_nxt),
    .divisor  (filled_nxt),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      filled_r    <= '0;
      total_r     <= '0;
      last_good_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            chosen_r    <= chosen_nxt;
            last_good_r <= chosen_nxt;
            state_r     <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          total_r   <= total_nxt;
          filled_r  <= filled_nxt;
          slot_r    <= slot_nxt;
          warming_r <= filled_nxt != CNT_W'(WINDOW);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            average_r     <= quotient;
            out_warming_r <= warming_r;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.average    = average_r;
  assign out_ch.warming_up = out_warming_r;

endmodule

// ----- tb/tma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_checker
// Watches both channels of the temperature moving average core. Each accepted
// request runs through a local copy of the filter (last-good substitution,
// ring buffer, running sum, divide by fill count), and each accepted result
// is compared field by field with the oldest predicted average.
// ----------------------------------------------------------------------------
module tma_checker #(
  parameter int WINDOW = 8
) (
  input  logic clk,
  input  logic rst_n,
  tma_in_if    in_ch,
  tma_out_if   out_ch,
  output int   errors,
  output int   pending
);
  import tma_pkg::*;

  localparam int TOTAL_W    = READING_W + $clog2(WINDOW);
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    reading_t average;
    logic     warming_up;
  } avg_result_t;

  avg_result_t               avg_due_q[$];
  reading_t                  window_hist[WINDOW];
  reading_t                  last_good;
  logic signed [TOTAL_W-1:0] window_sum;
  int unsigned               slot;
  int unsigned               fill_cnt;

  function automatic avg_result_t average_of_window(reading_t reading, logic fault);
    reading_t                  chosen;
    logic signed [TOTAL_W-1:0] quotient;
    avg_result_t               res;
    chosen = fault ? last_good : reading;
    last_good = chosen;
    window_sum = window_sum - window_hist[slot] + chosen;
    window_hist[slot] = chosen;
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    if (fill_cnt < WINDOW) begin
      fill_cnt++;
    end
    // signed divide truncates toward zero
    quotient = window_sum / $signed(TOTAL_W'(fill_cnt));
    res.average    = quotient[READING_W-1:0];
    res.warming_up = (fill_cnt < WINDOW);
    return res;
  endfunction

  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        window_hist[i] = '0;
      end
      last_good  = '0;
      window_sum = '0;
      slot       = 0;
      fill_cnt   = 0;
      avg_due_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.average    = out_ch.average;
        got.warming_up = out_ch.warming_up;
        if (avg_due_q.size() == 0) begin
          if (errors < REPORT_MAX) begin
            $display("%0t: unexpected result: average %0d warming_up %0b",
                     $realtime, $signed(got.average), got.warming_up);
          end
          errors <= errors + 1;
        end else begin
          want = avg_due_q.pop_front();
          if (got.average !== want.average || got.warming_up !== want.warming_up) begin
            if (errors < REPORT_MAX) begin
              $display("%0t: mismatch: average exp %0d got %0d, warming_up exp %0b got %0b",
                       $realtime, $signed(want.average), $signed(got.average),
                       want.warming_up, got.warming_up);
            end
            errors <= errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        avg_due_q.push_back(average_of_window(in_ch.reading, in_ch.fault));
      end
    end
    pending <= avg_due_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the temperature moving average core: a directed
// run over extreme readings, faults before and after a good reading and the
// warm-up edge, then random readings with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import tma_pkg::*;

  localparam int WINDOW       = 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_PCT     = 36;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 449;
  localparam int HOLD_AT      = 500;

  logic clk;
  logic rst_n;
  logic calm;
  int   errors;
  int   pending;
  int   cycles = 0;

  tma_in_if  in_ch ();
  tma_out_if out_ch ();

  temperature_moving_average_core #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  tma_checker #(
    .WINDOW(WINDOW)
  ) i_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_request(input reading_t reading, input logic fault);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.reading <= reading;
    in_ch.fault   <= fault;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_all_done();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    reading_t reading;
    logic     fault;
    int       pick;
    in_ch.valid   <= 1'b0;
    in_ch.reading <= '0;
    in_ch.fault   <= 1'b0;
    rst_n         <= 1'b0;
    calm          <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fault before any good reading: zero enters the buffer
    send_request(reading_t'(8191), 1'b1);
    // small negatives: truncation toward zero while warming up
    send_request(reading_t'(-1), 1'b0);
    send_request(reading_t'(-2), 1'b0);
    // full window at the top of the range, crossing the warm-up edge
    repeat (WINDOW) send_request(reading_t'(8191), 1'b0);
    // full window at the bottom, faults repeat the last good reading
    for (int i = 0; i < WINDOW; i++) begin
      send_request((i % 3 == 2) ? reading_t'(8191) : reading_t'(-8192), i % 3 == 2);
    end
    send_request(reading_t'(0), 1'b0);
    send_request(reading_t'(8191), 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= CALM_FIRST && n <= CALM_LAST);
      if (n == HOLD_AT) begin
        in_ch.valid <= 1'b0;
        wait_all_done();
      end
      pick = $urandom_range(9);
      case (pick)
        0: begin
          case ($urandom_range(3))
            0: reading = reading_t'(8191);
            1: reading = reading_t'(-8192);
            2: reading = reading_t'(-1);
            default: reading = '0;
          endcase
        end
        1, 2: reading = reading_t'(int'($urandom_range(15)) - 8);
        default: reading = reading_t'($urandom_range(16383));
      endcase
      fault = ($urandom_range(4) == 0);
      send_request(reading, fault);
    end
    in_ch.valid <= 1'b0;
    calm <= 1'b0;

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tma_pkg.sv
rtl/core/tma_if.sv
rtl/core/tma_history_ram.sv
rtl/core/tma_divider.sv
rtl/core/temperature_moving_average_core.sv
tb/tma_checker.sv
tb/tb_top.sv
